// ===== rtl/core/lfb_pkg.sv =====
// ----------------------------------------------------------------------------
// lfb_pkg
// Shared types and constants of the linear depth fog blend unit.
// ----------------------------------------------------------------------------
package lfb_pkg;

    // Field widths
    localparam int DIST_W     = 14;
    localparam int COLOR_W    = 8;
    localparam int DENS_W     = 7;
    localparam int HEIGHT_W   = 12;
    localparam int CFG_DATA_W = 14;
    localparam int CFG_IDX_W  = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FOG_START    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_END      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_RED      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_GREEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FOG_BLUE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DENSITY      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd6;

    // Register reset values
    localparam logic [DIST_W-1:0]   RST_FOG_START    = 14'd0;
    localparam logic [DIST_W-1:0]   RST_FOG_END      = 14'd5000;
    localparam logic [COLOR_W-1:0]  RST_FOG_COLOR    = 8'd200;
    localparam logic [DENS_W-1:0]   RST_DENSITY      = 7'd10;
    localparam logic [HEIGHT_W-1:0] RST_FRAME_HEIGHT = 12'd1080;

    // Depth scale and density percent
    localparam int DEPTH_SCALE = 10000;
    localparam int DEPTH_SCALE_W = 14;
    localparam logic [DENS_W-1:0] DENS_MAX = 7'd100;

    // floor(2^32 / 100) for the divide-by-100 of the density scaling
    localparam int DENS_RECIP       = 42949672;
    localparam int DENS_RECIP_W     = 26;
    localparam int DENS_RECIP_SHIFT = 32;

    typedef struct packed {
        logic [DIST_W-1:0]   fog_start;
        logic [DIST_W-1:0]   fog_end;
        logic [COLOR_W-1:0]  fog_red;
        logic [COLOR_W-1:0]  fog_green;
        logic [COLOR_W-1:0]  fog_blue;
        logic [DENS_W-1:0]   density;
        logic [HEIGHT_W-1:0] frame_height;
    } cfg_t;

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } pixel_t;

endpackage

// ===== rtl/core/lfb_pipe_div.sv =====
// ----------------------------------------------------------------------------
// lfb_pipe_div
// Pipelined restoring divider, one quotient bit per stage, with side payload.
// ----------------------------------------------------------------------------
module lfb_pipe_div #(
    parameter int QW  = 16,
    parameter int RW  = 14,
    parameter int PLW = 24
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  logic           in_valid,
    input  logic [RW-1:0]  in_rem,
    input  logic [QW-1:0]  in_dividend,
    input  logic [RW-1:0]  divisor,
    input  logic [PLW-1:0] in_payload,
    output logic           out_valid,
    output logic [QW-1:0]  out_quotient,
    output logic [PLW-1:0] out_payload
);

    // Stage k holds partial remainder, dividend/quotient shift word, payload
    logic           vld_s [1:QW];
    logic [RW-1:0]  rem_s [1:QW];
    logic [QW-1:0]  dq_s  [1:QW];
    logic [PLW-1:0] pl_s  [1:QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic           vld_in;
        logic [RW-1:0]  rem_in;
        logic [QW-1:0]  dq_in;
        logic [PLW-1:0] pl_in;
        logic [RW:0]    trial;
        logic [RW:0]    diff;
        logic           qbit;
        logic [RW-1:0]  rem_next;

        // Stage source: divider inputs for the first stage, else the stage before
        if (k == 0) begin : g_src_in
            assign vld_in = in_valid;
            assign rem_in = in_rem;
            assign dq_in  = in_dividend;
            assign pl_in  = in_payload;
        end
        else begin : g_src_stage
            assign vld_in = vld_s[k];
            assign rem_in = rem_s[k];
            assign dq_in  = dq_s[k];
            assign pl_in  = pl_s[k];
        end

        // One shift-subtract step
        always_comb
        begin
            trial    = {rem_in, dq_in[QW-1]};
            diff     = trial - {1'b0, divisor};
            qbit     = (trial >= {1'b0, divisor});
            rem_next = qbit ? diff[RW-1:0] : trial[RW-1:0];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_s[k+1] <= 1'b0;
            end
            else if (en)
            begin
                vld_s[k+1] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_s[k+1] <= rem_next;
                dq_s[k+1]  <= {dq_in[QW-2:0], qbit};
                pl_s[k+1]  <= pl_in;
            end
        end
    end

    assign out_valid    = vld_s[QW];
    assign out_quotient = dq_s[QW];
    assign out_payload  = pl_s[QW];

endmodule

// ===== rtl/core/lfb_factor.sv =====
// ----------------------------------------------------------------------------
// lfb_factor
// Depth from row, linear fog ratio and density scaling into the blend factor.
// ----------------------------------------------------------------------------
module lfb_factor #(
    parameter int ROW_BITS  = 12,
    parameter int FRAC_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  logic [ROW_BITS-1:0]  row,
    input  lfb_pkg::pixel_t      in_pix,
    input  lfb_pkg::cfg_t        cfg,
    output logic                 out_valid,
    output logic [FRAC_BITS:0]   out_f,
    output lfb_pkg::pixel_t      out_pix
);

    localparam int DEPTH_W = ROW_BITS + lfb_pkg::DEPTH_SCALE_W;
    localparam int PIX_W   = $bits(lfb_pkg::pixel_t);
    localparam int X_W     = FRAC_BITS + lfb_pkg::DENS_W;
    localparam int P_W     = X_W + lfb_pkg::DENS_RECIP_W;
    localparam int F_W     = FRAC_BITS + 1;
    localparam logic [F_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // Static terms of the configuration
    logic [lfb_pkg::HEIGHT_W-1:0] h_eff;
    logic [lfb_pkg::DENS_W-1:0]   dens_eff;
    logic                         ends_equal;
    logic                         den_pos;
    logic [lfb_pkg::DIST_W-1:0]   den;

    always_comb
    begin
        h_eff      = (cfg.frame_height == '0) ? lfb_pkg::HEIGHT_W'(1) : cfg.frame_height;
        dens_eff   = (cfg.density > lfb_pkg::DENS_MAX) ? lfb_pkg::DENS_MAX : cfg.density;
        ends_equal = (cfg.fog_end == cfg.fog_start);
        den_pos    = (cfg.fog_end > cfg.fog_start);
        den        = den_pos ? (cfg.fog_end - cfg.fog_start) : (cfg.fog_start - cfg.fog_end);
    end

    // Stage A: row * 10000
    logic                 valid_a_reg;
    logic [DEPTH_W-1:0]   prod_a_reg;
    lfb_pkg::pixel_t      pix_a_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_a_reg <= DEPTH_W'(row) * DEPTH_W'(lfb_pkg::DEPTH_SCALE);
            pix_a_reg  <= in_pix;
        end
    end

    // Depth divider: depth = prod / h
    logic               valid_dd;
    logic [DEPTH_W-1:0] depth_dd;
    logic [PIX_W-1:0]   pl_dd;

    lfb_pipe_div #(
        .QW  (DEPTH_W),
        .RW  (lfb_pkg::HEIGHT_W),
        .PLW (PIX_W)
    ) u_depth_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (valid_a_reg),
        .in_rem       ('0),
        .in_dividend  (prod_a_reg),
        .divisor      (h_eff),
        .in_payload   (pix_a_reg),
        .out_valid    (valid_dd),
        .out_quotient (depth_dd),
        .out_payload  (pl_dd)
    );

    // Stage B: numerator and special cases
    logic               num_pos;
    logic [DEPTH_W-1:0] start_x;
    logic [DEPTH_W-1:0] num;
    logic               sat_b_next;
    logic               zero_b_next;

    always_comb
    begin
        start_x = DEPTH_W'(cfg.fog_start);
        num_pos = (depth_dd > start_x);
        num     = num_pos ? (depth_dd - start_x) : (start_x - depth_dd);
        if (ends_equal)
        begin
            sat_b_next  = num_pos;
            zero_b_next = !num_pos;
        end
        else if ((num == '0) || (num_pos != den_pos))
        begin
            sat_b_next  = 1'b0;
            zero_b_next = 1'b1;
        end
        else
        begin
            // ratio at or above one clamps
            sat_b_next  = (num >= DEPTH_W'(den));
            zero_b_next = 1'b0;
        end
    end

    logic                       valid_b_reg;
    logic                       sat_b_reg;
    logic                       zero_b_reg;
    logic [lfb_pkg::DIST_W-1:0] rem_b_reg;
    logic [PIX_W-1:0]           pix_b_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_b_reg <= valid_dd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sat_b_reg  <= sat_b_next;
            zero_b_reg <= zero_b_next;
            // remainder start must stay below the divisor
            rem_b_reg  <= (sat_b_next || zero_b_next) ? '0 : num[lfb_pkg::DIST_W-1:0];
            pix_b_reg  <= pl_dd;
        end
    end

    // Ratio divider: fraction bits of num / den
    logic                 valid_rd;
    logic [FRAC_BITS-1:0] q_rd;
    logic [PIX_W+1:0]     pl_rd;

    lfb_pipe_div #(
        .QW  (FRAC_BITS),
        .RW  (lfb_pkg::DIST_W),
        .PLW (PIX_W + 2)
    ) u_ratio_div (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (en),
        .in_valid     (valid_b_reg),
        .in_rem       (rem_b_reg),
        .in_dividend  ('0),
        .divisor      (den),
        .in_payload   ({sat_b_reg, zero_b_reg, pix_b_reg}),
        .out_valid    (valid_rd),
        .out_quotient (q_rd),
        .out_payload  (pl_rd)
    );

    // Stage C: clamp and scale by density
    logic [F_W-1:0] ratio;

    always_comb
    begin
        if (pl_rd[PIX_W+1])
        begin
            ratio = ONE;
        end
        else if (pl_rd[PIX_W])
        begin
            ratio = '0;
        end
        else
        begin
            ratio = {1'b0, q_rd};
        end
    end

    logic             valid_c_reg;
    logic [X_W-1:0]   x_c_reg;
    lfb_pkg::pixel_t  pix_c_reg;

    // Stage D: reciprocal multiply for the divide by 100
    logic [P_W-1:0]   recip_prod;
    logic             valid_d_reg;
    logic [F_W-1:0]   q0_d_reg;
    logic [X_W-1:0]   x_d_reg;
    lfb_pkg::pixel_t  pix_d_reg;

    assign recip_prod = P_W'(x_c_reg) * P_W'(lfb_pkg::DENS_RECIP);

    // Stage E: one-step correction of the quotient
    logic [X_W-1:0]   qm;
    logic [X_W-1:0]   rmd;
    logic [F_W-1:0]   f_next;
    logic             valid_e_reg;
    logic [F_W-1:0]   f_e_reg;
    lfb_pkg::pixel_t  pix_e_reg;

    always_comb
    begin
        qm     = X_W'(q0_d_reg) * X_W'(lfb_pkg::DENS_MAX);
        rmd    = x_d_reg - qm;
        f_next = (rmd >= X_W'(lfb_pkg::DENS_MAX)) ? (q0_d_reg + F_W'(1)) : q0_d_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_c_reg <= 1'b0;
            valid_d_reg <= 1'b0;
            valid_e_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_c_reg <= valid_rd;
            valid_d_reg <= valid_c_reg;
            valid_e_reg <= valid_d_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_c_reg   <= X_W'(ratio) * X_W'(dens_eff);
            pix_c_reg <= lfb_pkg::pixel_t'(pl_rd[PIX_W-1:0]);
            q0_d_reg  <= recip_prod[lfb_pkg::DENS_RECIP_SHIFT +: F_W];
            x_d_reg   <= x_c_reg;
            pix_d_reg <= pix_c_reg;
            f_e_reg   <= f_next;
            pix_e_reg <= pix_d_reg;
        end
    end

    assign out_valid = valid_e_reg;
    assign out_f     = f_e_reg;
    assign out_pix   = pix_e_reg;

endmodule

// ===== rtl/core/lfb_blend_lane.sv =====
// ----------------------------------------------------------------------------
// lfb_blend_lane
// One color channel: pix * (1 - f) + fog * f, truncated and saturated.
// ----------------------------------------------------------------------------
module lfb_blend_lane #(
    parameter int FRAC_BITS = 16
) (
    input  logic                        clk,
    input  logic                        en,
    input  logic [lfb_pkg::COLOR_W-1:0] pix,
    input  logic [lfb_pkg::COLOR_W-1:0] fog,
    input  logic [FRAC_BITS:0]          f,
    output logic [lfb_pkg::COLOR_W-1:0] out_color
);

    localparam int F_W = FRAC_BITS + 1;
    localparam int M_W = F_W + lfb_pkg::COLOR_W;
    localparam int S_W = M_W + 1;
    localparam logic [F_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [S_W-FRAC_BITS-1:0] COLOR_MAX = {2'b00, {lfb_pkg::COLOR_W{1'b1}}};

    logic [F_W-1:0] inv_f;
    logic [M_W-1:0] pix_term_reg;
    logic [M_W-1:0] fog_term_reg;
    logic [S_W-1:0] sum;
    logic [S_W-FRAC_BITS-1:0] whole;
    logic [lfb_pkg::COLOR_W-1:0] out_color_reg;

    assign inv_f = ONE - f;

    // Products, then sum and saturate
    always_comb
    begin
        sum   = S_W'(pix_term_reg) + S_W'(fog_term_reg);
        whole = sum[S_W-1:FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pix_term_reg  <= M_W'(pix) * M_W'(inv_f);
            fog_term_reg  <= M_W'(fog) * M_W'(f);
            out_color_reg <= (whole > COLOR_MAX) ? {lfb_pkg::COLOR_W{1'b1}}
                                                 : whole[lfb_pkg::COLOR_W-1:0];
        end
    end

    assign out_color = out_color_reg;

endmodule

// ===== rtl/core/linear_depth_fog_blend_unit.sv =====
// ----------------------------------------------------------------------------
// linear_depth_fog_blend_unit
// Linear depth fog: row-derived depth, clamped fog factor, per-channel blend.
// ----------------------------------------------------------------------------
//  channel   dir  handshake         payload (low bit up)
//  s_axis    in   s_tvalid/tready   row, in_red, in_green, in_blue
//  m_axis    out  m_tvalid/tready   out_red, out_green, out_blue
//  cfg       in   cfg_wr_en         cfg_index, cfg_data
//
//  One pixel per clock while the skid stage is empty; the two dividers
//  resolve one quotient bit per stage.
//  Reset loads the register defaults and empties the pipeline.
//  A full skid stage freezes the whole pipeline; s_tready comes straight from a register.
// ----------------------------------------------------------------------------
module linear_depth_fog_blend_unit #(
    parameter int ROW_BITS  = 12,
    parameter int FRAC_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // row, in_red, in_green, in_blue
    input  logic [((ROW_BITS+31)/8)*8-1:0]    s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // out_red, out_green, out_blue
    output logic [23:0]                       m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [lfb_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lfb_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int CW = lfb_pkg::COLOR_W;

    // Configuration registers
    lfb_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fog_start    <= lfb_pkg::RST_FOG_START;
            cfg_reg.fog_end      <= lfb_pkg::RST_FOG_END;
            cfg_reg.fog_red      <= lfb_pkg::RST_FOG_COLOR;
            cfg_reg.fog_green    <= lfb_pkg::RST_FOG_COLOR;
            cfg_reg.fog_blue     <= lfb_pkg::RST_FOG_COLOR;
            cfg_reg.density      <= lfb_pkg::RST_DENSITY;
            cfg_reg.frame_height <= lfb_pkg::RST_FRAME_HEIGHT;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                lfb_pkg::REG_FOG_START:    cfg_reg.fog_start    <= cfg_data;
                lfb_pkg::REG_FOG_END:      cfg_reg.fog_end      <= cfg_data;
                lfb_pkg::REG_FOG_RED:      cfg_reg.fog_red      <= cfg_data[CW-1:0];
                lfb_pkg::REG_FOG_GREEN:    cfg_reg.fog_green    <= cfg_data[CW-1:0];
                lfb_pkg::REG_FOG_BLUE:     cfg_reg.fog_blue     <= cfg_data[CW-1:0];
                lfb_pkg::REG_DENSITY:      cfg_reg.density      <= cfg_data[lfb_pkg::DENS_W-1:0];
                lfb_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data[lfb_pkg::HEIGHT_W-1:0];
                default: ;
            endcase
        end
    end

    // Pipeline advances unless the skid stage is occupied
    logic skid_valid_reg;
    logic en;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    // Unpack input transfer
    lfb_pkg::pixel_t in_pix;

    assign in_pix.red   = s_tdata[ROW_BITS +: CW];
    assign in_pix.green = s_tdata[ROW_BITS + CW +: CW];
    assign in_pix.blue  = s_tdata[ROW_BITS + 2*CW +: CW];

    // Fog factor
    logic             valid_f;
    logic [FRAC_BITS:0] f_val;
    lfb_pkg::pixel_t  pix_f;

    lfb_factor #(
        .ROW_BITS  (ROW_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_factor (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .row       (s_tdata[ROW_BITS-1:0]),
        .in_pix    (in_pix),
        .cfg       (cfg_reg),
        .out_valid (valid_f),
        .out_f     (f_val),
        .out_pix   (pix_f)
    );

    // Color lanes
    lfb_pkg::pixel_t lane_pix;

    lfb_blend_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_red (
        .clk       (clk),
        .en        (en),
        .pix       (pix_f.red),
        .fog       (cfg_reg.fog_red),
        .f         (f_val),
        .out_color (lane_pix.red)
    );

    lfb_blend_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_green (
        .clk       (clk),
        .en        (en),
        .pix       (pix_f.green),
        .fog       (cfg_reg.fog_green),
        .f         (f_val),
        .out_color (lane_pix.green)
    );

    lfb_blend_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_blue (
        .clk       (clk),
        .en        (en),
        .pix       (pix_f.blue),
        .fog       (cfg_reg.fog_blue),
        .f         (f_val),
        .out_color (lane_pix.blue)
    );

    // Valid alongside the two lane stages
    logic valid_l1_reg;
    logic valid_l2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_l1_reg <= 1'b0;
            valid_l2_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_l1_reg <= valid_f;
            valid_l2_reg <= valid_l1_reg;
        end
    end

    // Merge lanes into output register with skid stage
    logic            out_valid_reg;
    lfb_pkg::pixel_t out_data_reg;
    lfb_pkg::pixel_t skid_data_reg;
    logic            out_load;

    assign out_load = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (out_load)
        begin
            out_valid_reg <= valid_l2_reg;
        end
        else if (valid_l2_reg)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_tready)
            begin
                out_data_reg <= skid_data_reg;
            end
        end
        else if (out_load)
        begin
            if (valid_l2_reg)
            begin
                out_data_reg <= lane_pix;
            end
        end
        else if (valid_l2_reg)
        begin
            skid_data_reg <= lane_pix;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Checks
    a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage holds data while output is empty");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && !m_tready |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("skid data lost during stall");

    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && m_tready |=> out_valid_reg && out_data_reg == $past(skid_data_reg))
        else $error("skid data not moved to output");

    a_frozen_pipe: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(valid_l2_reg) && $stable(lane_pix))
        else $error("pipeline moved while frozen");

endmodule

// ===== verif/lfb_fog_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfb_fog_checker
// Scoreboard for the linear depth fog blend unit: it tracks the register
// writes, predicts the fogged pixel of every input transfer and compares each
// output transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module lfb_fog_checker #(
    parameter int S_W = 40
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // row, in_red, in_green, in_blue
    input  logic [S_W-1:0]                 s_tdata,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    // out_red, out_green, out_blue
    input  logic [23:0]                    m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           cfg_wr_en,
    input  logic [lfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lfb_pkg::CFG_DATA_W-1:0] cfg_data,
    output int                             fail_count,
    output int                             checked,
    output int                             pending
);

    localparam int              ROW_W      = 12;
    localparam int              FRAC       = 16;
    localparam longint unsigned UNIT       = 64'd1 << FRAC;
    localparam int              REPORT_MAX = 10;

    lfb_pkg::cfg_t   regs;
    lfb_pkg::pixel_t fogged_q[$];

    initial
    begin
        fail_count = 0;
        checked    = 0;
        pending    = 0;
    end

    // Clamped linear factor, scaled by density percent
    function automatic longint unsigned fog_weight(input longint unsigned depth);
        longint unsigned st;
        longint unsigned en;
        longint unsigned num;
        longint unsigned den;
        longint unsigned ratio;
        longint unsigned dens;
        bit              num_pos;
        bit              den_pos;
        st = 64'(regs.fog_start);
        en = 64'(regs.fog_end);
        if (en == st)
        begin
            // step when the ramp has no width
            ratio = (depth > st) ? UNIT : 64'd0;
        end
        else
        begin
            num_pos = depth > st;
            den_pos = en > st;
            num     = num_pos ? depth - st : st - depth;
            den     = den_pos ? en - st : st - en;
            // opposite signs give a negative quotient, clamped to zero
            if (num == 64'd0 || num_pos != den_pos)
                ratio = 64'd0;
            else
            begin
                ratio = (num << FRAC) / den;
                if (ratio > UNIT)
                    ratio = UNIT;
            end
        end
        dens = (regs.density > lfb_pkg::DENS_MAX) ? 64'(lfb_pkg::DENS_MAX)
                                                  : 64'(regs.density);
        return (ratio * dens) / 64'd100;
    endfunction

    function automatic logic [lfb_pkg::COLOR_W-1:0] blend(input longint unsigned pix,
                                                          input longint unsigned fog,
                                                          input longint unsigned f);
        longint unsigned v;
        v = (pix * (UNIT - f) + fog * f) >> FRAC;
        return (v > 64'd255) ? 8'd255 : v[lfb_pkg::COLOR_W-1:0];
    endfunction

    function automatic lfb_pkg::pixel_t fogged_pixel(input logic [ROW_W-1:0] row,
                                                     input lfb_pkg::pixel_t px);
        longint unsigned h;
        longint unsigned depth;
        longint unsigned f;
        lfb_pkg::pixel_t res;
        // zero height counts as one row
        h     = (regs.frame_height == '0) ? 64'd1 : 64'(regs.frame_height);
        depth = (64'(row) * 64'(lfb_pkg::DEPTH_SCALE)) / h;
        f     = fog_weight(depth);
        res.red   = blend(64'(px.red), 64'(regs.fog_red), f);
        res.green = blend(64'(px.green), 64'(regs.fog_green), f);
        res.blue  = blend(64'(px.blue), 64'(regs.fog_blue), f);
        return res;
    endfunction

    // Register shadow, prediction and comparison
    always @(posedge clk or negedge rst_n)
    begin
        lfb_pkg::pixel_t got;
        lfb_pkg::pixel_t want;
        if (!rst_n)
        begin
            regs.fog_start    <= lfb_pkg::RST_FOG_START;
            regs.fog_end      <= lfb_pkg::RST_FOG_END;
            regs.fog_red      <= lfb_pkg::RST_FOG_COLOR;
            regs.fog_green    <= lfb_pkg::RST_FOG_COLOR;
            regs.fog_blue     <= lfb_pkg::RST_FOG_COLOR;
            regs.density      <= lfb_pkg::RST_DENSITY;
            regs.frame_height <= lfb_pkg::RST_FRAME_HEIGHT;
            fogged_q.delete();
            pending = 0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    lfb_pkg::REG_FOG_START:
                        regs.fog_start    <= cfg_data[lfb_pkg::DIST_W-1:0];
                    lfb_pkg::REG_FOG_END:
                        regs.fog_end      <= cfg_data[lfb_pkg::DIST_W-1:0];
                    lfb_pkg::REG_FOG_RED:
                        regs.fog_red      <= cfg_data[lfb_pkg::COLOR_W-1:0];
                    lfb_pkg::REG_FOG_GREEN:
                        regs.fog_green    <= cfg_data[lfb_pkg::COLOR_W-1:0];
                    lfb_pkg::REG_FOG_BLUE:
                        regs.fog_blue     <= cfg_data[lfb_pkg::COLOR_W-1:0];
                    lfb_pkg::REG_DENSITY:
                        regs.density      <= cfg_data[lfb_pkg::DENS_W-1:0];
                    lfb_pkg::REG_FRAME_HEIGHT:
                        regs.frame_height <= cfg_data[lfb_pkg::HEIGHT_W-1:0];
                    default: ;
                endcase
            end

            // output transfer against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                got = lfb_pkg::pixel_t'(m_tdata);
                if (fogged_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_MAX)
                        $display("%0t: result r=%0d g=%0d b=%0d with nothing pending",
                                 $realtime, got.red, got.green, got.blue);
                end
                else
                begin
                    want = fogged_q.pop_front();
                    checked++;
                    if (got.red !== want.red || got.green !== want.green ||
                        got.blue !== want.blue)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_MAX)
                            $display("%0t: result %0d exp r=%0d g=%0d b=%0d got r=%0d g=%0d b=%0d",
                                     $realtime, checked, want.red, want.green, want.blue,
                                     got.red, got.green, got.blue);
                    end
                end
            end

            // input transfer: predict with the current registers
            if (s_tvalid && s_tready)
                fogged_q.push_back(fogged_pixel(s_tdata[ROW_W-1:0],
                                                lfb_pkg::pixel_t'(s_tdata[ROW_W+23:ROW_W])));
            pending = fogged_q.size();
        end
    end

endmodule

// ===== verif/tb_linear_depth_fog_blend_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_linear_depth_fog_blend_unit
// Drives pixels through the fog blend unit under bursty input and a stalling
// output, reprograms the fog registers between phases (directed corner cases,
// then random settings) and takes the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_linear_depth_fog_blend_unit;

    localparam int ROW_W      = 12;
    localparam int S_W        = ((ROW_W + 31) / 8) * 8;
    localparam int LATENCY    = ROW_W + 16 + 22;
    localparam int IDLE_LIMIT = 3000;
    localparam int PHASES     = 10;
    localparam int PHASE_LEN  = 55;

    // index with no register behind it
    localparam logic [lfb_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PATTERN} rx_mode_t;

    logic                           clk;
    logic                           rst_n;
    // row, in_red, in_green, in_blue
    logic [S_W-1:0]                 s_tdata;
    logic                           s_tvalid;
    logic                           s_tready;
    // out_red, out_green, out_blue
    logic [23:0]                    m_tdata;
    logic                           m_tvalid;
    logic                           m_tready;
    logic                           cfg_wr_en;
    logic [lfb_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [lfb_pkg::CFG_DATA_W-1:0] cfg_data;

    int fail_count;
    int checked;
    int pending;
    int pixels_sent;
    int settings_used;
    int idle_cycles;
    int cur_height;

    linear_depth_fog_blend_unit #(
        .ROW_BITS  (ROW_W),
        .FRAC_BITS (16)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tdata   (s_tdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .m_tdata   (m_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    lfb_fog_checker #(
        .S_W (S_W)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tdata    (s_tdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .m_tdata    (m_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .fail_count (fail_count),
        .checked    (checked),
        .pending    (pending)
    );

    // 8 ns clock
    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Output stalls: ready always, at random, or from a rotating mask, in modes picked at random
    rx_mode_t    rx_mode;
    int          rx_left = 0;
    int          rx_pct;
    logic [15:0] rx_mask;

    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = rx_mode_t'($urandom_range(2));
            rx_left = $urandom_range(300, 50);
            rx_pct  = $urandom_range(90, 30);
            rx_mask = 16'($urandom) | 16'h0001;
        end
        rx_left--;
        case (rx_mode)
            RX_ALWAYS: m_tready <= 1'b1;
            RX_RANDOM: m_tready <= ($urandom_range(99) < rx_pct);
            default:
            begin
                m_tready <= rx_mask[0];
                rx_mask = {rx_mask[0], rx_mask[15:1]};
            end
        endcase
    end

    // Watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: %0d cycles without a transfer, %0d results pending",
                         idle_cycles, pending);
                $display("tb_linear_depth_fog_blend_unit: done, errors");
                $finish;
            end
        end
    end

    function automatic lfb_pkg::pixel_t make_px(input int r, input int g, input int b);
        lfb_pkg::pixel_t px;
        px.red   = r[7:0];
        px.green = g[7:0];
        px.blue  = b[7:0];
        return px;
    endfunction

    // One pixel transfer; valid stays high until the next item or a gap
    task automatic send_pixel(input logic [ROW_W-1:0] row, input lfb_pkg::pixel_t px);
        @(negedge clk);
        s_tdata  <= {{(S_W - ROW_W - 24){1'b0}}, px, row};
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        pixels_sent++;
    endtask

    task automatic write_reg(input logic [lfb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [lfb_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic program_all(input logic [13:0] st, input logic [13:0] en,
                               input logic [13:0] r, input logic [13:0] g,
                               input logic [13:0] b, input logic [13:0] dens,
                               input logic [13:0] height);
        write_reg(lfb_pkg::REG_FOG_START, st);
        write_reg(lfb_pkg::REG_FOG_END, en);
        write_reg(lfb_pkg::REG_FOG_RED, r);
        write_reg(lfb_pkg::REG_FOG_GREEN, g);
        write_reg(lfb_pkg::REG_FOG_BLUE, b);
        write_reg(lfb_pkg::REG_DENSITY, dens);
        write_reg(lfb_pkg::REG_FRAME_HEIGHT, height);
        cur_height = int'(height[lfb_pkg::HEIGHT_W-1:0]);
        settings_used++;
    endtask

    // Drop valid, drain every pending result, then let the pipeline run empty
    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    function automatic logic [7:0] rand_color();
        case ($urandom_range(7))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] rand_row();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            2, 3: return ROW_W'($urandom);
            // mostly rows inside the frame so the ramp is crossed
            default: return ROW_W'($urandom_range((cur_height == 0) ? 1 : cur_height));
        endcase
    endfunction

    task automatic random_settings();
        logic [13:0] st;
        logic [13:0] en;
        logic [6:0]  dens;
        logic [11:0] height;
        case ($urandom_range(4))
            0: st = 14'd0;
            1: st = 14'd10000;
            2: st = 14'($urandom_range(16383, 10001));
            default: st = 14'($urandom_range(10000));
        endcase
        case ($urandom_range(6))
            0: en = st;
            1: en = 14'd0;
            2: en = 14'd10000;
            3: en = st + 14'($urandom_range(50, 1));
            4: en = 14'($urandom_range(16383));
            default: en = 14'($urandom_range(10000));
        endcase
        case ($urandom_range(4))
            0: dens = 7'd0;
            1: dens = lfb_pkg::DENS_MAX;
            2: dens = 7'($urandom_range(127, 101));
            default: dens = 7'($urandom_range(100));
        endcase
        case ($urandom_range(5))
            0: height = 12'd0;
            1: height = 12'd1;
            2: height = 12'd4095;
            3: height = lfb_pkg::RST_FRAME_HEIGHT;
            default: height = 12'($urandom_range(4095, 1));
        endcase
        // bits above the color, density and height widths are written at random too
        program_all(st, en,
                    {6'($urandom), rand_color()},
                    {6'($urandom), rand_color()},
                    {6'($urandom), rand_color()},
                    {7'($urandom), dens},
                    {2'($urandom), height});
    endtask

    // Stimulus
    initial
    begin
        int left;
        int burst;
        int gap;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        pixels_sent   = 0;
        settings_used = 1;
        idle_cycles   = 0;
        cur_height    = int'(lfb_pkg::RST_FRAME_HEIGHT);
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset defaults; row zero sits on fog_start
        send_pixel(12'd0, make_px(0, 0, 0));
        send_pixel(12'd4095, make_px(255, 255, 255));
        send_pixel(12'd1080, make_px(255, 0, 128));
        send_pixel(12'd540, make_px(0, 255, 17));
        send_pixel(12'd1, make_px(200, 100, 50));
        settle();

        // equal start and end: step around depth 3000
        program_all(14'd3000, 14'd3000, 14'd0, 14'd255, 14'd128, 14'd100, 14'd1000);
        send_pixel(12'd300, make_px(255, 0, 0));
        send_pixel(12'd301, make_px(0, 0, 255));
        send_pixel(12'd299, make_px(100, 100, 100));
        settle();

        // end below start: beyond start, mid ramp, clamp to full
        program_all(14'd8000, 14'd2000, 14'd255, 14'd255, 14'd255, 14'd100, 14'd1000);
        send_pixel(12'd900, make_px(10, 20, 30));
        send_pixel(12'd500, make_px(0, 128, 255));
        send_pixel(12'd0, make_px(255, 0, 77));
        settle();

        // zero height, density above 100, start and end above 10000,
        // masked upper data bits and a write to an unused index
        program_all(14'd16383, 14'd12000, 14'h3F00, 14'h3FFF, 14'h2A55,
                    14'h3FFF, 14'd0);
        write_reg(REG_UNUSED, 14'h1234);
        send_pixel(12'd0, make_px(255, 255, 0));
        send_pixel(12'd1, make_px(0, 0, 255));
        send_pixel(12'd4095, make_px(33, 66, 99));
        settle();

        // density zero leaves the pixel alone
        program_all(14'd0, 14'd1, 14'd255, 14'd0, 14'd255, 14'd0, 14'd4095);
        send_pixel(12'd4095, make_px(12, 250, 7));
        send_pixel(12'd2000, make_px(255, 0, 255));
        settle();
        write_reg(lfb_pkg::REG_DENSITY, 14'(lfb_pkg::DENS_MAX));
        send_pixel(12'd0, make_px(1, 2, 3));
        send_pixel(12'd1, make_px(0, 255, 0));
        settle();

        // start and end both above 10000
        program_all(14'd10001, 14'd16383, 14'd7, 14'd77, 14'd177, 14'd100, 14'd1);
        send_pixel(12'd2, make_px(90, 180, 240));
        send_pixel(12'd1, make_px(240, 180, 90));
        settle();

        // Random phases under bursty traffic
        for (int ph = 0; ph < PHASES; ph++)
        begin
            random_settings();
            left = PHASE_LEN;
            while (left > 0)
            begin
                burst = $urandom_range(40, 1);
                if (burst > left)
                    burst = left;
                repeat (burst)
                begin
                    send_pixel(rand_row(), make_px(rand_color(), rand_color(), rand_color()));
                    left--;
                end
                gap = $urandom_range(12);
                if (gap != 0)
                begin
                    @(negedge clk);
                    s_tvalid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
            settle();
        end

        $display("coverage: %0d pixels under %0d register settings, %0d results compared",
                 pixels_sent, settings_used, checked);
        $display("mismatches counted: %0d", fail_count);
        if (fail_count == 0)
            $display("tb_linear_depth_fog_blend_unit: done, clean");
        else
            $display("tb_linear_depth_fog_blend_unit: done, errors");
        $finish;
    end

endmodule

// ===== linear_depth_fog_blend_unit.f =====
rtl/core/lfb_pkg.sv
rtl/core/lfb_pipe_div.sv
rtl/core/lfb_factor.sv
rtl/core/lfb_blend_lane.sv
rtl/core/linear_depth_fog_blend_unit.sv
verif/lfb_fog_checker.sv
verif/tb_linear_depth_fog_blend_unit.sv
